[design/dpt_pkg.sv]
// ----------------------------------------------------------------------------
// dpt_pkg
// Shared types, sizes and codes of the demand paging page table.
// ----------------------------------------------------------------------------
package dpt_pkg;

	localparam int PROC_COUNT      = 8;
	localparam int PAGES_PER_PROC  = 64;
	localparam int PHYS_FRAMES     = 256;
	localparam int RESERVED_FRAMES = 8;

	localparam int ENTRIES    = PROC_COUNT * PAGES_PER_PROC;
	localparam int ENTRY_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int PROC_IDX_W = (PROC_COUNT > 1) ? $clog2(PROC_COUNT) : 1;

	localparam logic [1:0] ST_HIT   = 2'd0;
	localparam logic [1:0] ST_FAULT = 2'd1;
	localparam logic [1:0] ST_OOM   = 2'd2;

	typedef struct packed {
		logic [2:0] process_id;
		logic [5:0] page;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  frame;
		logic [7:0]  ref_count;
		logic [8:0]  process_faults;
		logic [15:0] process_refs;
		logic [8:0]  allocated_frames;
	} rsp_t;

	// page table entry
	typedef struct packed {
		logic       valid;
		logic [7:0] frame;
		logic [7:0] refs;
	} pte_t;

	// per-process counters
	typedef struct packed {
		logic [8:0]  faults;
		logic [15:0] refs;
	} pcnt_t;

	typedef struct packed {
		logic               rd_en;
		logic               wr_en;
		logic [ENTRY_W-1:0] addr;
		pte_t               wdata;
	} pte_cmd_t;

	typedef struct packed {
		logic                  rd_en;
		logic                  wr_en;
		logic [PROC_IDX_W-1:0] addr;
		pcnt_t                 wdata;
	} pcnt_cmd_t;

	// fold the 3-bit process id into range
	function automatic logic [PROC_IDX_W-1:0] proc_idx(input logic [2:0] pid);
		return PROC_IDX_W'(int'(pid) % PROC_COUNT);
	endfunction

	function automatic logic [ENTRY_W-1:0] entry_idx(input req_t r);
		logic [5:0] pg;
		pg = 6'(int'(r.page) % PAGES_PER_PROC);
		return ENTRY_W'(proc_idx(r.process_id)) * ENTRY_W'(PAGES_PER_PROC) + ENTRY_W'(pg);
	endfunction

endpackage

[design/demand_paging_page_table.sv]
// ----------------------------------------------------------------------------
// demand_paging_page_table
// Per-process single-level page tables with demand paging: hits bump the
// entry's reference count, faults take frames from a bump pointer.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------
//  req      | req_valid / req_stall | dpt_pkg::req_t (process, page)
//  rsp      | rsp_valid / rsp_stall | dpt_pkg::rsp_t (status, frame, counts)
//  cfg      | cfg_valid / cfg_ready | cfg_data: first free frame
//
// For each reference the entry and counter memories are read in the
// transfer cycle, then updated and written back in the write-back state.
// After reset a clearing pass over all 512 entries (one entry per cycle)
// runs before the first reference is taken; configuration writes are held
// off only while a reference is in write-back.
// A stalled result holds the write-back cycle until the output register frees.
// ----------------------------------------------------------------------------
module demand_paging_page_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  dpt_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output dpt_pkg::rsp_t  rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [8:0]     cfg_data
);

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t          state_q;
	dpt_pkg::req_t   req_s1;
	dpt_pkg::rsp_t   rsp_q;
	logic            rsp_valid_q;
	logic            halted_q;
	logic [8:0]      next_frame_q;

	dpt_pkg::pte_cmd_t  pte_cmd;
	dpt_pkg::pte_t      pte_rd;
	logic               pte_busy;
	dpt_pkg::pcnt_cmd_t pc_cmd;
	dpt_pkg::pcnt_t     pc_rd;
	logic               pc_busy;

	logic           req_xfer;
	logic           cfg_xfer;
	logic           can_out;
	logic           done;
	logic           hit;
	logic           alloc;
	logic           upd;
	dpt_pkg::pte_t  pte_new;
	dpt_pkg::pcnt_t pc_new;
	dpt_pkg::pcnt_t pc_res;
	logic [9:0]     alloc_sum;
	dpt_pkg::rsp_t  rsp_new;

	dpt_pte_mem u_pte (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (pte_cmd),
		.rdata  (pte_rd),
		.busy   (pte_busy)
	);

	dpt_pcnt_mem u_pcnt (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (pc_cmd),
		.rdata  (pc_rd),
		.busy   (pc_busy)
	);

	assign req_stall = pte_busy | pc_busy | (state_q != S_IDLE);
	assign req_xfer  = req_valid & ~req_stall;
	assign cfg_ready = (state_q != S_EXEC);
	assign cfg_xfer  = cfg_valid & cfg_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign can_out = ~rsp_valid_q | ~rsp_stall;
	assign done    = (state_q == S_EXEC) & can_out;

	always_comb begin
		hit   = ~halted_q & pte_rd.valid;
		alloc = ~halted_q & ~pte_rd.valid & (int'(next_frame_q) < dpt_pkg::PHYS_FRAMES)
			& (next_frame_q != 9'h1FF);
		upd   = hit | alloc;

		pte_new.valid = 1'b1;
		if (hit) begin
			pte_new.frame = pte_rd.frame;
			pte_new.refs  = pte_rd.refs + 8'd1;
		end else begin
			pte_new.frame = next_frame_q[7:0];
			pte_new.refs  = 8'd1;
		end

		pc_new.faults = (alloc && pc_rd.faults != 9'h1FF) ? pc_rd.faults + 9'd1 : pc_rd.faults;
		pc_new.refs   = (pc_rd.refs != 16'hFFFF) ? pc_rd.refs + 16'd1 : pc_rd.refs;
		pc_res        = upd ? pc_new : pc_rd;

		alloc_sum = 10'(dpt_pkg::RESERVED_FRAMES) + {1'b0, pc_res.faults};

		rsp_new.status           = hit ? dpt_pkg::ST_HIT : (alloc ? dpt_pkg::ST_FAULT
			: dpt_pkg::ST_OOM);
		rsp_new.frame            = upd ? pte_new.frame : 8'd0;
		rsp_new.ref_count        = upd ? pte_new.refs : 8'd0;
		rsp_new.process_faults   = pc_res.faults;
		rsp_new.process_refs     = pc_res.refs;
		rsp_new.allocated_frames = alloc_sum[9] ? 9'h1FF : alloc_sum[8:0];

		// read on transfer, write back when the result lands
		pte_cmd.rd_en = req_xfer;
		pte_cmd.wr_en = done & upd;
		pte_cmd.addr  = req_xfer ? dpt_pkg::entry_idx(req) : dpt_pkg::entry_idx(req_s1);
		pte_cmd.wdata = pte_new;

		pc_cmd.rd_en  = req_xfer;
		pc_cmd.wr_en  = done & upd;
		pc_cmd.addr   = req_xfer ? dpt_pkg::proc_idx(req.process_id)
			: dpt_pkg::proc_idx(req_s1.process_id);
		pc_cmd.wdata  = pc_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rsp_valid_q  <= 1'b0;
			halted_q     <= 1'b0;
			next_frame_q <= '0;
			req_s1       <= '0;
			rsp_q        <= '0;
		end else begin
			if (done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_xfer) begin
				next_frame_q <= cfg_data;
			end else if (done && alloc) begin
				next_frame_q <= next_frame_q + 9'd1;
			end
			case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						req_s1  <= req;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					// hold until the output register is free
					if (can_out) begin
						rsp_q   <= rsp_new;
						state_q <= S_IDLE;
						if (!upd) begin
							halted_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(pte_busy || pc_busy) |-> req_stall)
		else $error("reference taken during clearing pass");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt flag dropped");

	a_oom_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == dpt_pkg::ST_OOM)
		|-> (rsp.frame == 8'd0 && rsp.ref_count == 8'd0))
		else $error("out of memory result carries a frame");

	a_exec_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> req_stall)
		else $error("reference taken during write-back");

	a_halt_reports_oom: assert property (@(posedge clk) disable iff (!arst_n)
		(done && halted_q) |=> (rsp_valid && rsp.status == dpt_pkg::ST_OOM))
		else $error("halted block answered other than out of memory");

endmodule

[design/dpt_pte_mem.sv]
// ----------------------------------------------------------------------------
// dpt_pte_mem
// Page table entry memory, separate read and write enables, registered read data,
// cleared entry by entry after reset.
// ----------------------------------------------------------------------------
module dpt_pte_mem (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dpt_pkg::pte_cmd_t        cmd,
	output dpt_pkg::pte_t            rdata,
	output logic                     busy
);

	dpt_pkg::pte_t mem [dpt_pkg::ENTRIES];

	logic                        busy_q;
	logic [dpt_pkg::ENTRY_W-1:0] clr_idx_q;

	logic                        wr_en;
	logic [dpt_pkg::ENTRY_W-1:0] wr_addr;
	dpt_pkg::pte_t               wr_data;

	assign busy    = busy_q;
	assign wr_en   = busy_q | cmd.wr_en;
	assign wr_addr = busy_q ? clr_idx_q : cmd.addr;
	assign wr_data = busy_q ? '0 : cmd.wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_idx_q <= '0;
		end else if (busy_q) begin
			if (clr_idx_q == dpt_pkg::ENTRY_W'(dpt_pkg::ENTRIES - 1)) begin
				busy_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata <= mem[cmd.addr];
		end
	end

endmodule

[design/dpt_pcnt_mem.sv]
// ----------------------------------------------------------------------------
// dpt_pcnt_mem
// Per-process fault and reference counters, registered read data,
// zeroed entry by entry after reset.
// ----------------------------------------------------------------------------
module dpt_pcnt_mem (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dpt_pkg::pcnt_cmd_t       cmd,
	output dpt_pkg::pcnt_t           rdata,
	output logic                     busy
);

	dpt_pkg::pcnt_t mem [dpt_pkg::PROC_COUNT];

	logic                           busy_q;
	logic [dpt_pkg::PROC_IDX_W-1:0] clr_idx_q;

	logic                           wr_en;
	logic [dpt_pkg::PROC_IDX_W-1:0] wr_addr;
	dpt_pkg::pcnt_t                 wr_data;

	assign busy    = busy_q;
	assign wr_en   = busy_q | cmd.wr_en;
	assign wr_addr = busy_q ? clr_idx_q : cmd.addr;
	assign wr_data = busy_q ? '0 : cmd.wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_idx_q <= '0;
		end else if (busy_q) begin
			if (clr_idx_q == dpt_pkg::PROC_IDX_W'(dpt_pkg::PROC_COUNT - 1)) begin
				busy_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata <= mem[cmd.addr];
		end
	end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the demand paging page table. A behavioral copy of
// the tables, the frame pointer and the per-process counters predicts every
// result. Directed cases come first, then random working-set and scattered
// references under random idling and back-pressure. Frame exhaustion and the
// halted state are exercised last, since only reset leaves the halted state.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT = 200_000;
	localparam int CHUNK_REFS  = 50;
	localparam int MIX_CHUNKS  = 32;
	localparam int COUNT9_MAX  = 511;
	localparam int REFS16_MAX  = 65535;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	dpt_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	dpt_pkg::rsp_t rsp;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [8:0]    cfg_data  = '0;

	int gap_pct     = 30;
	int stall_pct   = 30;
	int hold_cycles = 0;
	int errors      = 0;
	int cycle_count = 0;

	// behavioral copy of the block state
	bit          pt_valid [dpt_pkg::ENTRIES];
	logic [7:0]  pt_frame [dpt_pkg::ENTRIES];
	logic [7:0]  pt_refs  [dpt_pkg::ENTRIES];
	logic [8:0]  free_next   = '0;
	logic [8:0]  proc_faults [dpt_pkg::PROC_COUNT];
	logic [15:0] proc_refs   [dpt_pkg::PROC_COUNT];
	bit          oom_halted  = 1'b0;

	dpt_pkg::rsp_t pending_translations [$];

	demand_paging_page_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Translate one reference and update the copied state.
	function automatic dpt_pkg::rsp_t translate_ref(input dpt_pkg::req_t r);
		int            p;
		int            e;
		int            alloc;
		dpt_pkg::rsp_t o;
		p = int'(r.process_id) % dpt_pkg::PROC_COUNT;
		e = p * dpt_pkg::PAGES_PER_PROC + int'(r.page) % dpt_pkg::PAGES_PER_PROC;
		o = '0;
		if (!oom_halted && pt_valid[e]) begin
			pt_refs[e] = pt_refs[e] + 8'd1;
			if (proc_refs[p] < REFS16_MAX) proc_refs[p] = proc_refs[p] + 16'd1;
			o.status    = dpt_pkg::ST_HIT;
			o.frame     = pt_frame[e];
			o.ref_count = pt_refs[e];
		end else if (!oom_halted && free_next < dpt_pkg::PHYS_FRAMES
				&& free_next < COUNT9_MAX) begin
			pt_valid[e] = 1'b1;
			pt_frame[e] = free_next[7:0];
			pt_refs[e]  = 8'd1;
			free_next   = free_next + 9'd1;
			if (proc_faults[p] < COUNT9_MAX) proc_faults[p] = proc_faults[p] + 9'd1;
			if (proc_refs[p] < REFS16_MAX) proc_refs[p] = proc_refs[p] + 16'd1;
			o.status    = dpt_pkg::ST_FAULT;
			o.frame     = pt_frame[e];
			o.ref_count = 8'd1;
		end else begin
			oom_halted = 1'b1;
			o.status   = dpt_pkg::ST_OOM;
		end
		alloc = dpt_pkg::RESERVED_FRAMES + int'(proc_faults[p]);
		o.process_faults   = proc_faults[p];
		o.process_refs     = proc_refs[p];
		o.allocated_frames = (alloc > COUNT9_MAX) ? 9'(COUNT9_MAX) : 9'(alloc);
		return o;
	endfunction

	function automatic string fmt_rsp(input dpt_pkg::rsp_t t);
		return $sformatf("st=%0d frame=%0d refc=%0d faults=%0d refs=%0d alloc=%0d",
			t.status, t.frame, t.ref_count, t.process_faults, t.process_refs,
			t.allocated_frames);
	endfunction

	function automatic void log_mismatch(input string msg);
		errors++;
		if (errors <= 10) $display("%s", msg);
	endfunction

	// Offer one reference, hold it until the transfer, then predict it.
	task automatic send_ref(input dpt_pkg::req_t r);
		int n;
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			n = $urandom_range(1, 4);
			@(negedge clk);
			req_valid = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid = 1'b1;
		req       = r;
		do @(posedge clk); while (req_stall);
		pending_translations.push_back(translate_ref(r));
	endtask

	task automatic drain_results();
		@(negedge clk);
		req_valid = 1'b0;
		while (pending_translations.size() != 0) @(posedge clk);
	endtask

	task automatic write_first_free(input logic [8:0] v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		free_next = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Refill the frame pointer if n faults could run it dry.
	task automatic ensure_frames(input int n);
		if (int'(free_next) + n > dpt_pkg::PHYS_FRAMES) begin
			drain_results();
			write_first_free(9'($urandom_range(0, 150)));
		end
	endtask

	task automatic test_first_references();
		write_first_free(9'd0);
		send_ref('{process_id: 3'd0, page: 6'd0});
		send_ref('{process_id: 3'd0, page: 6'd0});
		send_ref('{process_id: 3'd7, page: 6'd63});
		send_ref('{process_id: 3'd7, page: 6'd63});
		send_ref('{process_id: 3'd5, page: 6'd42});
		send_ref('{process_id: 3'd2, page: 6'd21});
		send_ref('{process_id: 3'd5, page: 6'd42});
		send_ref('{process_id: 3'd2, page: 6'd21});
		send_ref('{process_id: 3'd0, page: 6'd63});
		send_ref('{process_id: 3'd7, page: 6'd0});
		drain_results();
	endtask

	// Hand out the last frame; the pointer is then at the limit.
	task automatic test_top_frame();
		write_first_free(9'd255);
		send_ref('{process_id: 3'd3, page: 6'd17});
		send_ref('{process_id: 3'd3, page: 6'd17});
		drain_results();
	endtask

	// Hit one entry back to back until its 8-bit count wraps.
	task automatic test_ref_count_wrap();
		ensure_frames(1);
		gap_pct   = 0;
		stall_pct = 0;
		repeat (300) send_ref('{process_id: 3'd1, page: 6'd50});
		gap_pct   = 30;
		stall_pct = 30;
		drain_results();
	endtask

	// Hold the result side off while references keep coming, then pause
	// the sender until every result has been taken.
	task automatic test_backpressure();
		dpt_pkg::req_t r;
		ensure_frames(40);
		hold_cycles = 150;
		repeat (40) begin
			r.process_id = 3'($urandom_range(4, 5));
			r.page       = 6'($urandom_range(0, 11));
			send_ref(r);
		end
		drain_results();
	endtask

	task automatic test_random_mix();
		dpt_pkg::req_t r;
		logic [2:0]    hot_a;
		logic [2:0]    hot_b;
		logic [5:0]    hot_base;
		bit            hot;
		for (int c = 0; c < MIX_CHUNKS; c++) begin
			ensure_frames(CHUNK_REFS);
			hot      = ($urandom_range(0, 9) < 6);
			hot_a    = 3'($urandom());
			hot_b    = 3'($urandom());
			hot_base = 6'($urandom());
			for (int i = 0; i < CHUNK_REFS; i++) begin
				if (hot) begin
					r.process_id = $urandom_range(0, 1) ? hot_a : hot_b;
					r.page       = hot_base + 6'($urandom_range(0, 7));
				end else begin
					r.process_id = 3'($urandom());
					r.page       = 6'($urandom());
				end
				send_ref(r);
			end
		end
		drain_results();
	endtask

	// Run out of frames; everything after answers out of memory.
	task automatic test_out_of_memory();
		dpt_pkg::req_t r;
		dpt_pkg::req_t miss;
		bit            found;
		found = 1'b0;
		miss  = '0;
		for (int e = dpt_pkg::ENTRIES - 1; e >= 0; e--) begin
			if (!pt_valid[e]) begin
				miss.process_id = 3'(e / dpt_pkg::PAGES_PER_PROC);
				miss.page       = 6'(e % dpt_pkg::PAGES_PER_PROC);
				found           = 1'b1;
			end
		end
		drain_results();
		write_first_free(9'd256);
		send_ref('{process_id: 3'd0, page: 6'd0});
		send_ref('{process_id: 3'd7, page: 6'd63});
		if (found) send_ref(miss);
		send_ref('{process_id: 3'd0, page: 6'd0});
		send_ref('{process_id: 3'd7, page: 6'd63});
		drain_results();
		write_first_free(9'd511);
		r.process_id = 3'($urandom());
		r.page       = 6'($urandom());
		send_ref(r);
		send_ref(miss);
		drain_results();
		write_first_free(9'd0);
		send_ref(miss);
		send_ref('{process_id: 3'd2, page: 6'd21});
		drain_results();
	endtask

	initial begin : rsp_sink
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				rsp_stall = 1'b1;
				hold_cycles--;
			end else begin
				rsp_stall = ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin : check_rsp
		dpt_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_translations.size() == 0) begin
				log_mismatch({"unexpected result: ", fmt_rsp(rsp)});
			end else begin
				want = pending_translations.pop_front();
				if (rsp.status !== want.status || rsp.frame !== want.frame ||
						rsp.ref_count !== want.ref_count ||
						rsp.process_faults !== want.process_faults ||
						rsp.process_refs !== want.process_refs ||
						rsp.allocated_frames !== want.allocated_frames) begin
					log_mismatch({"mismatch: expected ", fmt_rsp(want),
						" actual ", fmt_rsp(rsp)});
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		for (int p = 0; p < dpt_pkg::PROC_COUNT; p++) begin
			proc_faults[p] = '0;
			proc_refs[p]   = '0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_first_references();
		test_top_frame();
		test_ref_count_wrap();
		test_backpressure();
		test_random_mix();
		test_out_of_memory();
		drain_results();
		repeat (16) @(posedge clk);
		errors += pending_translations.size();
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
